// ===== rtl/cia_pkg.sv =====
// Shared types and constants for the cubemap irradiance accumulator.
// No dependencies; the front, queue, back and top files import this package.
package cia_pkg;

    // Source face codes.
    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    // Result sum field width and its largest value.
    localparam int unsigned OUT_W = 40;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Colour (8 bits) times the Q1.15 weighted cosine (at most 17 bits).
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned W15_W   = 17;
    localparam int unsigned ADD_W   = COLOR_W + W15_W;

    // Depth of the queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Per-texel attributes that travel beside the arithmetic.
    typedef struct packed {
        logic [15:0]        weight;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
        logic               face_ok;
    } attr_t;

    // Classified request as held in the queue.
    typedef struct packed {
        logic signed [16:0] rx;
        logic signed [16:0] ry;
        logic signed [16:0] rz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        attr_t              attr;
    } item_t;

endpackage

// ===== rtl/cia_if.sv =====
// Handshake channels of the accumulator: texel requests in, irradiance results out.
// No dependencies.
interface cia_texel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        weight;
    logic [2:0]         source_face;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last_texel;

    modport source (
        output valid, dir_x, dir_y, dir_z, weight, source_face, red, green, blue,
               normal_x, normal_y, normal_z, last_texel,
        input  ready
    );
    modport sink (
        input  valid, dir_x, dir_y, dir_z, weight, source_face, red, green, blue,
               normal_x, normal_y, normal_z, last_texel,
        output ready
    );
endinterface

interface cia_result_if;
    logic        valid;
    logic        ready;
    logic [39:0] sum_red;
    logic [39:0] sum_green;
    logic [39:0] sum_blue;
    logic        saturated;

    modport source (
        output valid, sum_red, sum_green, sum_blue, saturated,
        input  ready
    );
    modport sink (
        input  valid, sum_red, sum_green, sum_blue, saturated,
        output ready
    );
endinterface

// ===== rtl/cia_front.sv =====
// Front part: accepts texel requests, rotates the direction to the source face
// and flags invalid face codes. Depends on cia_pkg and cia_if.
module cia_front (
    cia_texel_if.sink     texel,
    input  logic          queue_full,
    output logic          push,
    output cia_pkg::item_t push_item
);
    import cia_pkg::*;

    logic signed [16:0] ex;
    logic signed [16:0] ey;
    logic signed [16:0] ez;

    // A request is taken whenever the queue has room.
    assign texel.ready = !queue_full;
    assign push        = texel.valid && !queue_full;

    // Sign-extend so that negating minus one stays exact.
    assign ex = 17'(texel.dir_x);
    assign ey = 17'(texel.dir_y);
    assign ez = 17'(texel.dir_z);

    // Signed axis permutation per source face.
    always_comb
    begin
        push_item.nx             = texel.normal_x;
        push_item.ny             = texel.normal_y;
        push_item.nz             = texel.normal_z;
        push_item.attr.weight    = texel.weight;
        push_item.attr.red       = texel.red;
        push_item.attr.green     = texel.green;
        push_item.attr.blue      = texel.blue;
        push_item.attr.last      = texel.last_texel;
        push_item.attr.face_ok   = 1'b1;
        unique case (texel.source_face)
            FACE_POS_X:
            begin
                push_item.rx = ex;
                push_item.ry = ey;
                push_item.rz = ez;
            end
            FACE_NEG_X:
            begin
                push_item.rx = -ex;
                push_item.ry = ey;
                push_item.rz = -ez;
            end
            FACE_POS_Y:
            begin
                push_item.rx = -ez;
                push_item.ry = ex;
                push_item.rz = -ey;
            end
            FACE_NEG_Y:
            begin
                push_item.rx = -ez;
                push_item.ry = -ex;
                push_item.rz = ey;
            end
            FACE_POS_Z:
            begin
                push_item.rx = -ez;
                push_item.ry = ey;
                push_item.rz = ex;
            end
            FACE_NEG_Z:
            begin
                push_item.rx = ez;
                push_item.ry = ey;
                push_item.rz = -ex;
            end
            default:
            begin
                // Unused face code: the texel adds nothing but may still end the run.
                push_item.rx           = '0;
                push_item.ry           = '0;
                push_item.rz           = '0;
                push_item.attr.face_ok = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/cia_queue.sv =====
// Short first-in first-out queue of classified requests between front and back.
// Depends on cia_pkg.
module cia_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cia_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output cia_pkg::item_t pop_item
);
    import cia_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign avail    = (count_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> avail)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
`endif

endmodule

// ===== rtl/cia_back.sv =====
// Back part: dot product, solid-angle weighting, colour scaling and the saturating
// accumulators, plus the result register. Depends on cia_pkg and cia_if.
module cia_back #(
    parameter int unsigned ACC_WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             avail,
    input  cia_pkg::item_t   pop_item,
    output logic             pop,
    cia_result_if.source     result
);
    import cia_pkg::*;

    localparam int unsigned SUM_W = ((ACC_WIDTH > ADD_W) ? ACC_WIDTH : ADD_W) + 1;
    localparam int unsigned CLIP_W = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

    // Pipeline advance: only a finished run waiting on a full result register stalls.
    logic adv;

    // Stage 1: the three normal-direction products.
    logic               v1_reg;
    logic signed [31:0] px_next;
    logic signed [31:0] py_next;
    logic signed [31:0] pz_next;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] pz_reg;
    attr_t              attr1_reg;

    // Stage 2: dot product.
    logic               v2_reg;
    logic signed [32:0] dot_next;
    logic signed [32:0] dot_reg;
    attr_t              attr2_reg;

    // Stage 3: dot product times solid angle.
    logic               v3_reg;
    logic signed [49:0] prod_full;
    logic signed [48:0] prod_reg;
    attr_t              attr3_reg;

    // Stage 4: colour times weighted cosine.
    logic               v4_reg;
    logic               last4_reg;
    logic               pos3;
    logic [W15_W-1:0]   w15;
    logic [ADD_W-1:0]   add_next [3];
    logic [ADD_W-1:0]   add_reg [3];

    // Accumulators and result register.
    logic [ACC_WIDTH-1:0] acc_reg [3];
    logic [ACC_WIDTH-1:0] acc_next [3];
    logic [2:0]           hit;
    logic [2:0]           clipped;
    logic [OUT_W-1:0]     clip_val [3];
    logic                 ovf_reg;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_sum_reg [3];
    logic                 out_sat_reg;

    assign adv = !(v4_reg && last4_reg && out_valid_reg && !result.ready);
    assign pop = adv && avail;

    // Products; operands are sign-extended to the 32-bit result.
    assign px_next  = pop_item.nx * pop_item.rx;
    assign py_next  = pop_item.ny * pop_item.ry;
    assign pz_next  = pop_item.nz * pop_item.rz;
    assign dot_next = 33'(px_reg) + 33'(py_reg) + 33'(pz_reg);
    assign prod_full = dot_reg * $signed({1'b0, attr2_reg.weight});

    // Weighted cosine, truncated Q1.15, only for a strictly positive product.
    assign pos3 = attr3_reg.face_ok && !prod_reg[48] && (prod_reg != '0);
    assign w15  = pos3 ? prod_reg[47:31] : '0;

    always_comb
    begin
        add_next[0] = ADD_W'(attr3_reg.red) * ADD_W'(w15);
        add_next[1] = ADD_W'(attr3_reg.green) * ADD_W'(w15);
        add_next[2] = ADD_W'(attr3_reg.blue) * ADD_W'(w15);
    end

    // Saturating add and output clipping, one per colour channel.
    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        logic [SUM_W-1:0]     sum;
        logic [ACC_WIDTH-1:0] sat_val;
        logic                 adds;

        assign adds    = v4_reg && (add_reg[c] != '0);
        assign sum     = SUM_W'(acc_reg[c]) + SUM_W'(add_reg[c]);
        assign sat_val = (sum >= SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_WIDTH-1:0];
        assign acc_next[c] = adds ? sat_val : acc_reg[c];
        assign hit[c]      = adds && (sat_val == ACC_MAX);
        assign clipped[c]  = CLIP_W'(acc_next[c]) > CLIP_W'(OUT_MAX);
        assign clip_val[c] = clipped[c] ? OUT_MAX : OUT_W'(CLIP_W'(acc_next[c]));
    end

    // Stage valids, accumulator state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            acc_reg[0]    <= '0;
            acc_reg[1]    <= '0;
            acc_reg[2]    <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= avail;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
            // A new result may replace the one taken in the same cycle.
            if (adv && v4_reg && last4_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (adv && v4_reg)
            begin
                if (last4_reg)
                begin
                    acc_reg[0]    <= '0;
                    acc_reg[1]    <= '0;
                    acc_reg[2]    <= '0;
                    ovf_reg       <= 1'b0;
                end
                else
                begin
                    acc_reg[0] <= acc_next[0];
                    acc_reg[1] <= acc_next[1];
                    acc_reg[2] <= acc_next[2];
                    ovf_reg    <= ovf_reg || (|hit);
                end
            end
        end
    end

    // Pipeline payload and result data need no reset.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            pz_reg     <= pz_next;
            attr1_reg  <= pop_item.attr;
            dot_reg    <= dot_next;
            attr2_reg  <= attr1_reg;
            prod_reg   <= prod_full[48:0];
            attr3_reg  <= attr2_reg;
            add_reg[0] <= add_next[0];
            add_reg[1] <= add_next[1];
            add_reg[2] <= add_next[2];
            last4_reg  <= attr3_reg.last;
        end
        if (adv && v4_reg && last4_reg)
        begin
            out_sum_reg[0] <= clip_val[0];
            out_sum_reg[1] <= clip_val[1];
            out_sum_reg[2] <= clip_val[2];
            out_sat_reg    <= ovf_reg || (|hit) || (|clipped);
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.sum_red   = out_sum_reg[0];
    assign result.sum_green = out_sum_reg[1];
    assign result.sum_blue  = out_sum_reg[2];
    assign result.saturated = out_sat_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v4_reg && last4_reg) |=>
        (acc_reg[0] == '0 && acc_reg[1] == '0 && acc_reg[2] == '0 && !ovf_reg))
        else $error("accumulators not cleared after end of run");
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (acc_reg[0] == ACC_MAX || acc_reg[1] == ACC_MAX || acc_reg[2] == ACC_MAX))
        else $error("overflow flag set with no accumulator at maximum");
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v4_reg && last4_reg) |=> out_valid_reg)
        else $error("end of run did not load the result register");
`endif

endmodule

// ===== rtl/cubemap_irradiance_accumulator_top.sv =====
// The last texel of a run passes the queue, then the product, dot, weight and colour
// stages; the result register then loads the accumulator sums of the run.
// Throughput: one texel per cycle unless stalled; the saturating add closes the loop.
// A last texel waiting on an untaken result stalls the back pipeline; a 4-entry
// queue keeps accepting meanwhile. Reset (rst_n, async, low) clears sums and valids.
// Top level; depends on cia_pkg, cia_if, cia_front, cia_queue and cia_back.
module cubemap_irradiance_accumulator_top #(
    parameter int unsigned ACC_WIDTH = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    cia_texel_if.sink    texel,
    cia_result_if.source result
);
    import cia_pkg::*;

    logic  push;
    logic  queue_full;
    logic  pop;
    logic  avail;
    item_t push_item;
    item_t pop_item;

    // Accept and classify requests.
    cia_front u_front (
        .texel      (texel),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Decouple the front from the back.
    cia_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .avail     (avail),
        .pop_item  (pop_item)
    );

    // Weight and accumulate.
    cia_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .avail    (avail),
        .pop_item (pop_item),
        .pop      (pop),
        .result   (result)
    );

endmodule
